[rtl/core/pab_pkg.sv]
// shared types and constants of the pixel alpha blend block
`timescale 1ns / 1ps
`default_nettype none
package pab_pkg;

	// pixel format modes
	localparam logic [2:0] MODE_32   = 3'd0;
	localparam logic [2:0] MODE_24   = 3'd1;
	localparam logic [2:0] MODE_24M  = 3'd2;
	localparam logic [2:0] MODE_8M   = 3'd3;
	localparam logic [2:0] MODE_565  = 3'd4;
	localparam logic [2:0] MODE_565K = 3'd5;

	// register indexes on the configuration port
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_PERCENT = 2'd1;
	localparam logic [1:0] REG_KEY1    = 2'd2;
	localparam logic [1:0] REG_KEY2    = 2'd3;

	localparam logic [6:0] PERCENT_MAX   = 7'd100;
	localparam logic [6:0] PERCENT_RESET = 7'd50;

	// floor(x / 100) for x up to 25500 as (x * DIV100_MUL) >> DIV100_SHIFT
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	localparam logic [7:0] FULL_WEIGHT = 8'd255;

	typedef struct packed {
		logic [31:0] src_pixel;
		logic [31:0] dst_pixel;
		logic [15:0] second_src_pixel;
		logic [7:0]  mask_byte;
	} pab_in_t;

	typedef struct packed {
		logic [31:0] out_pixel;
		logic        was_blended;
	} pab_out_t;

endpackage
`default_nettype wire

[rtl/core/pixel_alpha_blend_top.sv]
// pixel alpha blend: four-stage pipeline blending one source pixel into one destination
//
// usage
//   input: an item transfers at a rising edge with start high and busy low; busy is
//   always low, so one item may enter every cycle
//   output: done is high for exactly one cycle with the result on result; the
//   receiver takes it at the edge that ends that cycle and cannot hold it off
//   stages: each item passes four register stages in order: operand capture
//   and percent scaling, alpha multiply and channel unpack, per-channel weight
//   multiply, clamp and repack, and its result is registered in the last one
//   throughput: one item per cycle, set by the fully pipelined multiply stages
//   configuration: APB port, registers pixel_mode, blend_percent, first_key and
//   second_key at byte addresses 0, 4, 8, 12; write them only while no item is
//   in flight
//   reset: arst_n clears the pipeline valid bits and loads the register reset
//   values (mode 32bpp, percent 50, keys zero); no result shows until an item
//   has entered after reset
`timescale 1ns / 1ps
`default_nettype none
module pixel_alpha_blend_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire pab_pkg::pab_in_t item,
	output logic                 done,
	output pab_pkg::pab_out_t    result,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import pab_pkg::*;

	// configuration registers
	logic [2:0]  pixel_mode_q;
	logic [6:0]  blend_percent_q;
	logic [15:0] first_key_q;
	logic [15:0] second_key_q;

	logic        cfg_write;
	logic [1:0]  cfg_index;

	assign pready    = 1'b1;
	assign busy      = 1'b0;
	assign cfg_write = psel & penable & pwrite & pready;
	assign cfg_index = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q    <= MODE_32;
			blend_percent_q <= PERCENT_RESET;
			first_key_q     <= '0;
			second_key_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODE:    pixel_mode_q    <= pwdata[2:0];
				REG_PERCENT: blend_percent_q <= pwdata[6:0];
				REG_KEY1:    first_key_q     <= pwdata[15:0];
				REG_KEY2:    second_key_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_index)
			REG_MODE:    prdata = {29'd0, pixel_mode_q};
			REG_PERCENT: prdata = {25'd0, blend_percent_q};
			REG_KEY1:    prdata = {16'd0, first_key_q};
			REG_KEY2:    prdata = {16'd0, second_key_q};
			default:     prdata = '0;
		endcase
	end

	// stage 1: capture operands, saturate percent and scale it by 255
	logic [6:0]  pct_sat;
	logic [14:0] pct_scaled;

	assign pct_sat    = (blend_percent_q > PERCENT_MAX) ? PERCENT_MAX : blend_percent_q;
	assign pct_scaled = {pct_sat, 8'd0} - 15'(pct_sat);

	logic        valid_s1;
	pab_in_t     item_s1;
	logic [2:0]  mode_s1;
	logic        key_hit_s1;
	logic [14:0] pct_scaled_s1;

	// stage 2: alpha, weights and unpacked channels
	logic [27:0]      alpha_prod;
	logic [7:0]       alpha;
	logic [7:0]       wd;
	logic [7:0]       ws;
	logic [3:0][7:0]  ch_d;
	logic [3:0][7:0]  ch_s;

	assign alpha_prod = 28'(pct_scaled_s1) * 28'(DIV100_MUL);
	assign alpha      = alpha_prod[DIV100_SHIFT +: 8];

	always_comb begin
		if (mode_s1 == MODE_24M || mode_s1 == MODE_8M) begin
			wd = item_s1.mask_byte;
			ws = FULL_WEIGHT - item_s1.mask_byte;
		end else begin
			wd = FULL_WEIGHT - alpha;
			ws = alpha;
		end
	end

	always_comb begin
		unique case (mode_s1)
			MODE_32: begin
				ch_d = item_s1.dst_pixel;
				ch_s = item_s1.src_pixel;
			end
			MODE_24, MODE_24M: begin
				ch_d = {8'd0, item_s1.dst_pixel[23:0]};
				ch_s = {8'd0, item_s1.src_pixel[23:0]};
			end
			MODE_8M: begin
				ch_d = {24'd0, item_s1.dst_pixel[7:0]};
				ch_s = {24'd0, item_s1.src_pixel[7:0]};
			end
			MODE_565, MODE_565K: begin
				// lane 2 red, lane 1 green, lane 0 blue, each widened to 8 bits
				ch_d = {8'd0, item_s1.dst_pixel[15:11], 3'd0,
					item_s1.dst_pixel[10:5], 2'd0, item_s1.dst_pixel[4:0], 3'd0};
				ch_s = {8'd0, item_s1.src_pixel[15:11], 3'd0,
					item_s1.src_pixel[10:5], 2'd0, item_s1.src_pixel[4:0], 3'd0};
			end
			default: begin
				ch_d = '0;
				ch_s = '0;
			end
		endcase
	end

	logic            valid_s2;
	logic [2:0]      mode_s2;
	logic            key_hit_s2;
	logic [31:0]     dst_s2;
	logic [7:0]      wd_s2;
	logic [7:0]      ws_s2;
	logic [3:0][7:0] ch_d_s2;
	logic [3:0][7:0] ch_s_s2;

	// stage 3: weighted sums per channel
	logic [3:0][16:0] mix_sum;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mix_sum[k] = 17'(ch_d_s2[k]) * 17'(wd_s2) + 17'(ch_s_s2[k]) * 17'(ws_s2);
		end
	end

	logic             valid_s3;
	logic [2:0]       mode_s3;
	logic             key_hit_s3;
	logic [31:0]      dst_s3;
	logic [3:0][16:0] mix_sum_s3;

	// stage 4: scale down, clamp and repack by mode
	logic [3:0][7:0] ch_out;
	pab_out_t        res_next;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ch_out[k] = (mix_sum_s3[k][16:8] > 9'd255) ? 8'hff : mix_sum_s3[k][15:8];
		end
	end

	always_comb begin
		res_next.was_blended = 1'b1;
		unique case (mode_s3)
			MODE_32:           res_next.out_pixel = ch_out;
			MODE_24, MODE_24M: res_next.out_pixel = {8'd0, ch_out[2], ch_out[1], ch_out[0]};
			MODE_8M:           res_next.out_pixel = {24'd0, ch_out[0]};
			MODE_565:          res_next.out_pixel = {16'd0, ch_out[2][7:3], ch_out[1][7:2],
				ch_out[0][7:3]};
			MODE_565K: begin
				if (key_hit_s3) begin
					res_next.out_pixel   = {16'd0, dst_s3[15:0]};
					res_next.was_blended = 1'b0;
				end else begin
					res_next.out_pixel = {16'd0, ch_out[2][7:3], ch_out[1][7:2],
						ch_out[0][7:3]};
				end
			end
			default: begin
				res_next.out_pixel   = dst_s3;
				res_next.was_blended = 1'b0;
			end
		endcase
	end

	logic     valid_s4;
	logic [2:0] mode_s4;
	pab_out_t res_s4;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		item_s1       <= item;
		mode_s1       <= pixel_mode_q;
		key_hit_s1    <= (item.src_pixel[15:0] == first_key_q) &&
			(item.second_src_pixel == second_key_q);
		pct_scaled_s1 <= pct_scaled;

		mode_s2    <= mode_s1;
		key_hit_s2 <= key_hit_s1;
		dst_s2     <= item_s1.dst_pixel;
		wd_s2      <= wd;
		ws_s2      <= ws;
		ch_d_s2    <= ch_d;
		ch_s_s2    <= ch_s;

		mode_s3    <= mode_s2;
		key_hit_s3 <= key_hit_s2;
		dst_s3     <= dst_s2;
		mix_sum_s3 <= mix_sum;

		mode_s4 <= mode_s3;
		res_s4  <= res_next;
	end

	assign done   = valid_s4;
	assign result = res_s4;

	// every accepted item later raises done with its result
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted item did not produce a result");

	// RGB565 results never carry bits above the 16-bit pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (mode_s4 == MODE_565 || mode_s4 == MODE_565K) |->
		result.out_pixel[31:16] == 16'd0)
		else $error("rgb565 result has upper bits set");

	// a kept destination only comes from keyed mode or an unused mode
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.was_blended |->
		(mode_s4 == MODE_565K || mode_s4 > MODE_565K))
		else $error("destination kept in a blending mode");

endmodule
`default_nettype wire
